@@ sv/pirc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the clamped PI regulator: word types, register indexes,
// reset values and divider result type. No dependencies.
package pirc_pkg;

  localparam int DataW = 32;
  localparam int RateW = 16;
  localparam int ProdW = 64;
  localparam int FracW = 16;
  localparam int TermW = ProdW - FracW;  // Q32.16 product after the shift
  localparam int WideW = TermW + 1;     // sums kept wide enough not to wrap
  localparam int CfgIdxW = 3;

  // command codes
  localparam logic CMD_STEP   = 1'b0;
  localparam logic CMD_REINIT = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_EXEC_RATE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INTEG_UPPER = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INTEG_LOWER = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OUT_UPPER   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OUT_LOWER   = 3'd6;

  // reset values
  localparam logic [RateW-1:0] RATE_RESET = 16'd1000;
  localparam logic signed [DataW-1:0] POS_FULL = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] NEG_FULL = 32'sh8000_0000;

  typedef struct packed {
    logic                    cmd;
    logic signed [DataW-1:0] error_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive_value;
    logic                    was_saturated;
  } out_word_t;

  typedef struct packed {
    logic                    done;
    logic signed [TermW-1:0] quot;
  } div_res_t;

endpackage

@@ sv/pirc_div.sv @@
`timescale 1ns / 1ps
// Iterative signed divider for the PI regulator: 48-bit signed dividend by
// 16-bit unsigned nonzero divisor, one quotient bit per cycle, truncating.
// Depends on pirc_pkg.
module pirc_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [pirc_pkg::TermW-1:0]    dividend,
  input  logic        [pirc_pkg::RateW-1:0]    divisor,
  output pirc_pkg::div_res_t                   res
);

  localparam int CntW = $clog2(pirc_pkg::TermW);
  localparam logic [CntW-1:0] LastCnt = CntW'(pirc_pkg::TermW - 1);

  logic                         busy_r;
  logic                         neg_r;
  logic [CntW-1:0]              cnt_r;
  logic [pirc_pkg::RateW-1:0]   rem_r;
  logic [pirc_pkg::TermW-1:0]   quo_r;
  pirc_pkg::div_res_t           res_r;

  logic [pirc_pkg::RateW:0]     rem_shift;
  logic [pirc_pkg::RateW:0]     diff;
  logic                         ge;
  logic [pirc_pkg::TermW-1:0]   quo_next;

  // trial subtract of the shifted partial remainder
  assign rem_shift = {rem_r, quo_r[pirc_pkg::TermW-1]};
  assign diff      = rem_shift - {1'b0, divisor};
  assign ge        = (rem_shift >= {1'b0, divisor});
  assign quo_next  = {quo_r[pirc_pkg::TermW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      res_r.done <= 1'b0;
    end else begin
      res_r.done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= dividend[pirc_pkg::TermW-1];
        quo_r  <= dividend[pirc_pkg::TermW-1] ? pirc_pkg::TermW'(-dividend)
                                               : pirc_pkg::TermW'(dividend);
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[pirc_pkg::RateW-1:0] : rem_shift[pirc_pkg::RateW-1:0];
        quo_r <= quo_next;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LastCnt) begin
          busy_r     <= 1'b0;
          res_r.done <= 1'b1;
          res_r.quot <= neg_r ? $signed(-quo_next) : $signed(quo_next);
        end
      end
    end
  end

  assign res = res_r;

endmodule

@@ sv/pi_regulator_clamped.sv @@
`timescale 1ns / 1ps
// Top level of the clamped PI regulator in signed Q16.16.
// Depends on pirc_pkg and pirc_div.
//
// Proportional-integral regulator. A step word carries one error sample; the
// block returns one word with the saturated drive value and a saturation
// flag. Proportional term is prop_gain * error (exact 64-bit product, floor
// shift by 16). The integral grows by (integ_gain * error) / exec_rate_hz,
// truncated toward zero, and is clamped to [integ_lower, integ_upper], upper
// test first. Zero integ_gain forces the integral to zero. A rate of zero
// acts as one. The sum is saturated to out_lower, then out_upper, lower test
// first. A reinit word clears the integral and returns zero.
// Sequence: one shared 32x32 multiplier is used twice, then a radix-2 divider
// produces one quotient bit per cycle; a step word then passes through the
// clamp, sum and saturate states (zero integ_gain skips the divide and the
// clamp) and a reinit word goes straight to the output hand-off. in_ready is
// high only when the sequencer is idle, and the sequencer returns to idle as
// the result loads, so a new word waits until the last result has loaded.
// The result sits in an output register, so the next word is taken while the
// previous result waits. Config writes are always accepted (cfg_ready is
// tied high) and must only be made while the block is idle; index 7 is
// ignored.
module pi_regulator_clamped (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pirc_pkg::in_word_t                 in_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pirc_pkg::out_word_t                out_word,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pirc_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [pirc_pkg::DataW-1:0]         cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MULP, S_MULI, S_DIVGO, S_DIVW, S_CLAMP, S_SUM, S_SAT, S_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic signed [pirc_pkg::DataW-1:0] prop_gain_r;
  logic signed [pirc_pkg::DataW-1:0] integ_gain_r;
  logic        [pirc_pkg::RateW-1:0] exec_rate_r;
  logic signed [pirc_pkg::DataW-1:0] integ_upper_r;
  logic signed [pirc_pkg::DataW-1:0] integ_lower_r;
  logic signed [pirc_pkg::DataW-1:0] out_upper_r;
  logic signed [pirc_pkg::DataW-1:0] out_lower_r;

  // datapath
  logic signed [pirc_pkg::DataW-1:0] err_r;
  logic signed [pirc_pkg::ProdW-1:0] prod_r;
  logic signed [pirc_pkg::TermW-1:0] prop_r;
  logic signed [pirc_pkg::WideW-1:0] acc_r;
  logic signed [pirc_pkg::DataW-1:0] term_r;
  logic signed [pirc_pkg::WideW-1:0] sum_r;
  logic signed [pirc_pkg::DataW-1:0] integral_r;
  pirc_pkg::out_word_t               res_r;
  pirc_pkg::out_word_t               out_word_r;
  logic                              out_valid_r;

  // shared multiplier: kp on the first pass, ki on the second
  logic signed [pirc_pkg::DataW-1:0] mul_b;
  logic signed [pirc_pkg::ProdW-1:0] mul_p;
  assign mul_b = (state_r == S_MULP) ? prop_gain_r : integ_gain_r;
  assign mul_p = pirc_pkg::ProdW'(err_r) * pirc_pkg::ProdW'(mul_b);

  // divider hookup: start pulses for one cycle, rate of zero acts as one
  logic                         div_start;
  logic [pirc_pkg::RateW-1:0]   div_den;
  pirc_pkg::div_res_t           div_res;
  assign div_start = (state_r == S_DIVGO);
  assign div_den   = (exec_rate_r == '0) ? pirc_pkg::RateW'(1) : exec_rate_r;

  pirc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ($signed(prod_r[pirc_pkg::ProdW-1:pirc_pkg::FracW])),
    .divisor  (div_den),
    .res      (div_res)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      exec_rate_r   <= pirc_pkg::RATE_RESET;
      integ_upper_r <= pirc_pkg::POS_FULL;
      integ_lower_r <= pirc_pkg::NEG_FULL;
      out_upper_r   <= pirc_pkg::POS_FULL;
      out_lower_r   <= pirc_pkg::NEG_FULL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pirc_pkg::REG_PROP_GAIN:   prop_gain_r   <= $signed(cfg_data);
        pirc_pkg::REG_INTEG_GAIN:  integ_gain_r  <= $signed(cfg_data);
        pirc_pkg::REG_EXEC_RATE:   exec_rate_r   <= cfg_data[pirc_pkg::RateW-1:0];
        pirc_pkg::REG_INTEG_UPPER: integ_upper_r <= $signed(cfg_data);
        pirc_pkg::REG_INTEG_LOWER: integ_lower_r <= $signed(cfg_data);
        pirc_pkg::REG_OUT_UPPER:   out_upper_r   <= $signed(cfg_data);
        pirc_pkg::REG_OUT_LOWER:   out_lower_r   <= $signed(cfg_data);
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      integral_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the output word once taken, unless the hand-off state reloads it
      if (out_valid_r && out_ready && (state_r != S_DONE)) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            err_r <= in_word.error_sample;
            if (in_word.cmd == pirc_pkg::CMD_REINIT) begin
              integral_r <= '0;
              res_r      <= '0;
              state_r    <= S_DONE;
            end else begin
              state_r <= S_MULP;
            end
          end
        end
        S_MULP: begin
          prod_r  <= mul_p;
          state_r <= S_MULI;
        end
        S_MULI: begin
          // floor shift of the kp product, then take the ki product
          prop_r <= prod_r[pirc_pkg::ProdW-1:pirc_pkg::FracW];
          prod_r <= mul_p;
          if (integ_gain_r == '0) begin
            integral_r <= '0;
            term_r     <= '0;
            state_r    <= S_SUM;
          end else begin
            state_r <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_res.done) begin
            acc_r   <= pirc_pkg::WideW'(integral_r) + pirc_pkg::WideW'(div_res.quot);
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          // upper limit is tested first
          if (acc_r > pirc_pkg::WideW'(integ_upper_r)) begin
            integral_r <= integ_upper_r;
            term_r     <= integ_upper_r;
          end else if (acc_r < pirc_pkg::WideW'(integ_lower_r)) begin
            integral_r <= integ_lower_r;
            term_r     <= integ_lower_r;
          end else begin
            integral_r <= acc_r[pirc_pkg::DataW-1:0];
            term_r     <= acc_r[pirc_pkg::DataW-1:0];
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          sum_r   <= pirc_pkg::WideW'(prop_r) + pirc_pkg::WideW'(term_r);
          state_r <= S_SAT;
        end
        S_SAT: begin
          // lower limit is tested first
          if (sum_r < pirc_pkg::WideW'(out_lower_r)) begin
            res_r.drive_value   <= out_lower_r;
            res_r.was_saturated <= 1'b1;
          end else if (sum_r > pirc_pkg::WideW'(out_upper_r)) begin
            res_r.drive_value   <= out_upper_r;
            res_r.was_saturated <= 1'b1;
          end else begin
            res_r.drive_value   <= sum_r[pirc_pkg::DataW-1:0];
            res_r.was_saturated <= 1'b0;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (!out_valid_r || out_ready) begin
            out_word_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a reinit word leaves the integral cleared
  a_reinit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_word.cmd == pirc_pkg::CMD_REINIT) |=> (integral_r == '0))
    else $error("integral not cleared after reinit");

  // the divider only finishes while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIVW))
    else $error("divider finished outside its wait state");

  // a new output word only comes from the hand-off state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("output word raised outside the hand-off state");

endmodule
